// ===== src/tile_grid_aabb_mover_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tile grid box mover
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TILE_GRID_AABB_MOVER_MACROS_SVH
`define TILE_GRID_AABB_MOVER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== src/tgam_pkg.sv =====
// ----------------------------------------------------------------------------
// tgam_pkg
// Types, constants and codes shared by the tile grid box mover.
// ----------------------------------------------------------------------------
package tgam_pkg;

    localparam int MAP_COLS_LOG2 = 6;
    localparam int MAP_ROWS_LOG2 = 6;
    localparam int MAP_IDX_W     = MAP_COLS_LOG2 + MAP_ROWS_LOG2;
    localparam int TILE_ADDR_W   = 12;
    localparam int MAP_DEPTH     = 1 << TILE_ADDR_W;
    localparam int ONE_PIXEL     = 256;
    localparam int FRAC_BITS     = 8;
    // working width for positions, edges and tile coordinates
    localparam int WW            = 36;
    localparam int CFG_DATA_W    = 24;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MOVE  = 1'b1;

    typedef enum logic [2:0] {
        CFG_GRAVITY_X    = 3'd0,
        CFG_GRAVITY_Y    = 3'd1,
        CFG_DELTA_TIME   = 3'd2,
        CFG_MAX_SPEED    = 3'd3,
        CFG_TILE_SHIFT_X = 3'd4,
        CFG_TILE_SHIFT_Y = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                   opcode;
        logic [11:0]            tile_addr;
        logic                   tile_solid;
        logic signed [31:0]     pos_x;
        logic signed [31:0]     pos_y;
        logic [23:0]            size_w;
        logic [23:0]            size_h;
        logic signed [23:0]     vel_x;
        logic signed [23:0]     vel_y;
        logic signed [23:0]     accel_x;
        logic signed [23:0]     accel_y;
        logic                   use_gravity;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]     new_pos_x;
        logic signed [31:0]     new_pos_y;
        logic signed [23:0]     new_vel_x;
        logic signed [23:0]     new_vel_y;
        logic                   hit_x;
        logic                   hit_y;
    } out_item_t;

    typedef struct packed {
        logic signed [23:0]     gravity_x;
        logic signed [23:0]     gravity_y;
        logic [15:0]            delta_time;
        logic [22:0]            max_speed;
        logic [3:0]             tile_shift_x;
        logic [3:0]             tile_shift_y;
    } cfg_t;

    typedef struct packed {
        logic                   clearing;
        logic                   busy;
    } back_status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_VEL,
        ST_POS,
        ST_EDGE,
        ST_ADDR,
        ST_READ,
        ST_RDW,
        ST_FIN
    } back_state_t;

endpackage

// ===== src/tgam_front.sv =====
// ----------------------------------------------------------------------------
// tgam_front
// Two-entry input queue; flags move transactions for the back end.
// ----------------------------------------------------------------------------
module tgam_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enq,
    input  tgam_pkg::in_item_t  enq_item,
    output logic                q_full,
    output logic                q_valid,
    output logic                q_is_move,
    output tgam_pkg::in_item_t  q_item,
    input  logic                deq
);
    import tgam_pkg::*;

    in_item_t    slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign q_full    = (count_reg == 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = slot_reg[rd_ptr_reg];
    assign q_is_move = (q_item.opcode == OP_MOVE);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ enq;
        rd_ptr_next = rd_ptr_reg ^ deq;
        count_next  = count_reg + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            slot_reg[wr_ptr_reg] <= enq_item;
        end
    end

endmodule

// ===== src/tgam_back.sv =====
// ----------------------------------------------------------------------------
// tgam_back
// Tile map memory and move sequencer: integrate, probe four tiles, resolve.
// ----------------------------------------------------------------------------
module tgam_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tgam_pkg::cfg_t          cfg,
    input  logic                    item_valid,
    input  logic                    item_is_move,
    input  tgam_pkg::in_item_t      item,
    output logic                    item_deq,
    output logic                    res_valid,
    output tgam_pkg::out_item_t     res,
    input  logic                    res_pop,
    output tgam_pkg::back_status_t  status
);
    import tgam_pkg::*;

    typedef struct packed {
        logic                   ok;
        logic [TILE_ADDR_W-1:0] addr;
    } tile_ref_t;

    function automatic tile_ref_t tile_lookup(input logic signed [WW-1:0] cx,
                                              input logic signed [WW-1:0] cy);
        tile_ref_t              r;
        logic [MAP_IDX_W-1:0]   idx;
        idx    = {cy[MAP_ROWS_LOG2-1:0], cx[MAP_COLS_LOG2-1:0]};
        r.ok   = ((cx >>> MAP_COLS_LOG2) == '0) && ((cy >>> MAP_ROWS_LOG2) == '0)
                 && (32'(idx) < MAP_DEPTH);
        r.addr = TILE_ADDR_W'(idx);
        return r;
    endfunction

    back_state_t state_reg, state_next;
    logic [TILE_ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0] rd_cnt_reg, rd_cnt_next;
    logic       res_valid_reg, res_valid_next;
    logic       cap_vld_reg;
    logic [1:0] cap_idx_reg;

    // tile map
    logic                   map_mem [MAP_DEPTH];
    logic                   mem_we;
    logic [TILE_ADDR_W-1:0] mem_waddr;
    logic                   mem_wdata;
    logic [TILE_ADDR_W-1:0] mem_raddr;
    logic                   mem_q_reg;

    // datapath
    in_item_t               it_reg;
    logic signed [24:0]     ax_reg, ay_reg;
    logic signed [26:0]     v1x_reg, v1y_reg;
    logic signed [WW-1:0]   nx_reg, ny_reg;
    logic                   dxneg_reg, dxnz_reg, dyneg_reg, dynz_reg;
    logic signed [WW-1:0]   lead_x_reg, lead_y_reg, cx1_reg, cy1_reg;
    logic signed [WW-1:0]   alx_reg, aly_reg;
    tile_ref_t              ref_reg [4];
    logic [3:0]             solid_reg;
    out_item_t              res_reg;

    logic                   load_res;
    logic [4:0]             sx, sy;
    logic signed [WW-1:0]   px_w, py_w, w_w, h_w;
    logic signed [WW-1:0]   mask_x, mask_y, ts_x, ts_y;
    logic signed [16:0]     dt_s;
    logic signed [41:0]     prod_ax, prod_ay;
    logic signed [43:0]     prod_vx, prod_vy;
    logic signed [27:0]     dx, dy;
    logic signed [WW-1:0]   nx_c, ny_c;
    logic signed [WW-1:0]   tx_lead, ty_lead, ty0, ty1, tx0, tx1;
    out_item_t              res_c;

    assign sx     = 5'd8 + 5'(cfg.tile_shift_x);
    assign sy     = 5'd8 + 5'(cfg.tile_shift_y);
    assign px_w   = WW'(it_reg.pos_x);
    assign py_w   = WW'(it_reg.pos_y);
    assign w_w    = $signed(WW'(it_reg.size_w));
    assign h_w    = $signed(WW'(it_reg.size_h));
    assign mask_x = {WW{1'b1}} <<< sx;
    assign mask_y = {WW{1'b1}} <<< sy;
    assign ts_x   = $signed(WW'(1)) <<< sx;
    assign ts_y   = $signed(WW'(1)) <<< sy;
    assign dt_s   = $signed({1'b0, cfg.delta_time});

    assign prod_ax = ax_reg * dt_s;
    assign prod_ay = ay_reg * dt_s;
    assign prod_vx = v1x_reg * dt_s;
    assign prod_vy = v1y_reg * dt_s;
    assign dx      = $signed(prod_vx[43:16]);
    assign dy      = $signed(prod_vy[43:16]);
    assign nx_c    = px_w + WW'(dx);
    assign ny_c    = py_w + WW'(dy);

    assign tx_lead = lead_x_reg >>> sx;
    assign ty_lead = lead_y_reg >>> sy;
    assign ty0     = py_w >>> sy;
    assign ty1     = cy1_reg >>> sy;
    assign tx0     = px_w >>> sx;
    assign tx1     = cx1_reg >>> sx;

    // resolve: snap on hit, clamp velocity, saturate position
    always_comb
    begin
        logic                   nz, hx, hy;
        logic signed [WW-1:0]   fx, fy;
        logic signed [26:0]     vx, vy, ms;
        nz = (it_reg.size_w != '0) && (it_reg.size_h != '0);
        hx = nz && dxnz_reg && (solid_reg[0] || solid_reg[1]);
        hy = nz && dynz_reg && (solid_reg[2] || solid_reg[3]);
        ms = $signed({4'd0, cfg.max_speed});
        fx = hx ? (dxneg_reg ? alx_reg + ts_x : alx_reg - w_w) : nx_reg;
        fy = hy ? (dyneg_reg ? aly_reg + ts_y : aly_reg - h_w) : ny_reg;
        vx = hx ? '0 : v1x_reg;
        vy = hy ? '0 : v1y_reg;
        if (nz)
        begin
            if (vx > ms)       vx = ms;
            else if (vx < -ms) vx = -ms;
            if (vy > ms)       vy = ms;
            else if (vy < -ms) vy = -ms;
        end
        else
        begin
            fx = px_w;
            fy = py_w;
            if (vx > 27'sd8388607)       vx = 27'sd8388607;
            else if (vx < -27'sd8388608) vx = -27'sd8388608;
            if (vy > 27'sd8388607)       vy = 27'sd8388607;
            else if (vy < -27'sd8388608) vy = -27'sd8388608;
        end
        if (fx > $signed(WW'(32'h7FFF_FFFF)))      fx = WW'(32'h7FFF_FFFF);
        else if (fx < $signed(WW'(32'sh8000_0000))) fx = WW'(32'sh8000_0000);
        if (fy > $signed(WW'(32'h7FFF_FFFF)))      fy = WW'(32'h7FFF_FFFF);
        else if (fy < $signed(WW'(32'sh8000_0000))) fy = WW'(32'sh8000_0000);
        res_c.new_pos_x = fx[31:0];
        res_c.new_pos_y = fy[31:0];
        res_c.new_vel_x = vx[23:0];
        res_c.new_vel_y = vy[23:0];
        res_c.hit_x     = hx;
        res_c.hit_y     = hy;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        item_deq       = 1'b0;
        load_res       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = it_reg.tile_addr;
        mem_wdata      = 1'b0;
        mem_raddr      = ref_reg[rd_cnt_reg].addr;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == TILE_ADDR_W'(MAP_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_deq = 1'b1;
                    if (item_is_move)
                    begin
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = item.tile_addr;
                        mem_wdata = item.tile_solid;
                    end
                end
            end
            ST_ACC:  state_next = ST_VEL;
            ST_VEL:  state_next = ST_POS;
            ST_POS:  state_next = ST_EDGE;
            ST_EDGE: state_next = ST_ADDR;
            ST_ADDR:
            begin
                rd_cnt_next = 2'd0;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 2'd1;
                if (rd_cnt_reg == 2'd3)
                begin
                    state_next = ST_RDW;
                end
            end
            ST_RDW:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (!res_valid_reg || res_pop)
                begin
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        res_valid_next = (res_valid_reg && !res_pop) || load_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rd_cnt_reg    <= '0;
            res_valid_reg <= 1'b0;
            cap_vld_reg   <= 1'b0;
            cap_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            res_valid_reg <= res_valid_next;
            cap_vld_reg   <= (state_reg == ST_READ);
            cap_idx_reg   <= rd_cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= map_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (item_deq)
        begin
            it_reg <= item;
        end
        if (state_reg == ST_ACC)
        begin
            ax_reg <= 25'(it_reg.accel_x)
                      + (it_reg.use_gravity ? 25'(cfg.gravity_x) : 25'sd0);
            ay_reg <= 25'(it_reg.accel_y)
                      + (it_reg.use_gravity ? 25'(cfg.gravity_y) : 25'sd0);
        end
        if (state_reg == ST_VEL)
        begin
            v1x_reg <= 27'(it_reg.vel_x) + 27'($signed(prod_ax[41:16]));
            v1y_reg <= 27'(it_reg.vel_y) + 27'($signed(prod_ay[41:16]));
        end
        if (state_reg == ST_POS)
        begin
            nx_reg    <= nx_c;
            ny_reg    <= ny_c;
            dxneg_reg <= dx[27];
            dyneg_reg <= dy[27];
            dxnz_reg  <= (dx != '0);
            dynz_reg  <= (dy != '0);
        end
        if (state_reg == ST_EDGE)
        begin
            lead_x_reg <= dxneg_reg ? nx_reg : nx_reg + w_w;
            lead_y_reg <= dyneg_reg ? ny_reg : ny_reg + h_w;
            cx1_reg    <= px_w + w_w - WW'(ONE_PIXEL);
            cy1_reg    <= py_w + h_w - WW'(ONE_PIXEL);
        end
        if (state_reg == ST_ADDR)
        begin
            alx_reg    <= lead_x_reg & mask_x;
            aly_reg    <= lead_y_reg & mask_y;
            ref_reg[0] <= tile_lookup(tx_lead, ty0);
            ref_reg[1] <= tile_lookup(tx_lead, ty1);
            ref_reg[2] <= tile_lookup(tx0, ty_lead);
            ref_reg[3] <= tile_lookup(tx1, ty_lead);
        end
        if (cap_vld_reg)
        begin
            solid_reg[cap_idx_reg] <= mem_q_reg && ref_reg[cap_idx_reg].ok;
        end
        if (load_res)
        begin
            res_reg <= res_c;
        end
    end

    assign res_valid       = res_valid_reg;
    assign res             = res_reg;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.busy     = (state_reg != ST_IDLE);

endmodule

// ===== src/tile_grid_aabb_mover.sv =====
// ----------------------------------------------------------------------------
// tile_grid_aabb_mover
// A move leaves the input queue when the sequencer is idle, passes through
// accelerate, velocity, position, edge, address, four reads of the single-
// read-port tile map, read wait and finish, and its result is registered.
// A tile write gives no result; writes go one per cycle while the sequencer
// is idle. A waiting unpopped result holds the next move; moves never overlap.
// Reset: after rst_n the map is swept clear, 4096 cycles with full held high.
// ----------------------------------------------------------------------------
module tile_grid_aabb_mover (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  tgam_pkg::in_item_t              item,
    output logic                            empty,
    input  logic                            pop,
    output tgam_pkg::out_item_t             result,
    input  logic                            write_en,
    input  logic [2:0]                      write_index,
    input  logic [tgam_pkg::CFG_DATA_W-1:0] write_data
);
    import tgam_pkg::*;

`include "tile_grid_aabb_mover_macros.svh"

    // Front end: a two-entry queue takes transactions while the back end is
    // busy on a move or a finished result waits to be popped.
    // Back end: owns the 4096 x 1 tile map and a sequencer that integrates
    // velocity, forms the leading-edge tile coordinates, reads the two corner
    // tiles per axis and resolves snap, clamp and saturation.

    cfg_t         cfg_reg;
    logic         q_full, q_valid, q_is_move, q_deq;
    in_item_t     q_item;
    logic         enq;
    logic         res_valid;
    back_status_t status;

    // nothing is taken while the map clear sweep runs
    assign full  = q_full || status.clearing;
    assign enq   = push && !full;
    assign empty = !res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_x    <= 24'sd0;
            cfg_reg.gravity_y    <= 24'sd250880;
            cfg_reg.delta_time   <= 16'd1092;
            cfg_reg.max_speed    <= 23'd128000;
            cfg_reg.tile_shift_x <= 4'd4;
            cfg_reg.tile_shift_y <= 4'd4;
        end
        else if (write_en)
        begin
            unique case (write_index)
                CFG_GRAVITY_X:    cfg_reg.gravity_x    <= write_data;
                CFG_GRAVITY_Y:    cfg_reg.gravity_y    <= write_data;
                CFG_DELTA_TIME:   cfg_reg.delta_time   <= write_data[15:0];
                CFG_MAX_SPEED:    cfg_reg.max_speed    <= write_data[22:0];
                CFG_TILE_SHIFT_X: cfg_reg.tile_shift_x <= write_data[3:0];
                CFG_TILE_SHIFT_Y: cfg_reg.tile_shift_y <= write_data[3:0];
                default:          ;
            endcase
        end
    end

    tgam_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enq       (enq),
        .enq_item  (item),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .q_is_move (q_is_move),
        .q_item    (q_item),
        .deq       (q_deq)
    );

    tgam_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item_valid   (q_valid),
        .item_is_move (q_is_move),
        .item         (q_item),
        .item_deq     (q_deq),
        .res_valid    (res_valid),
        .res          (result),
        .res_pop      (pop && res_valid),
        .status       (status)
    );

    // clear sweep must hold off input and never present a result
    `ASSERT_NEVER(a_clear_blocks_input, status.clearing && !full, "input open during map clear")
    `ASSERT_PROP(a_clear_no_result, status.clearing |-> empty, "result during map clear")
    // a stopped axis leaves zero velocity
    `ASSERT_PROP(a_hit_x_stops, (!empty && result.hit_x) |-> (result.new_vel_x == '0), "hit_x vel")
    `ASSERT_PROP(a_hit_y_stops, (!empty && result.hit_y) |-> (result.new_vel_y == '0), "hit_y vel")

endmodule
